>>> hdl/isodr_pkg.sv
// isodr_pkg: types and constants shared by the directory record parser
// no dependencies; compiled first

package isodr_pkg;

	// record layout limits
	localparam logic [7:0] MIN_RECORD    = 8'd33;
	localparam logic [7:0] MAX_NAME      = 8'd222;
	localparam logic [7:0] BAD_FLAG_MASK = 8'hFC;
	localparam int unsigned DIR_FLAG_BIT = 1;

	// byte positions within a record
	localparam logic [7:0] POS_REC_LEN   = 8'd0;
	localparam logic [7:0] POS_EXT_ATTR  = 8'd1;
	localparam logic [7:0] POS_SECTOR_0  = 8'd2;
	localparam logic [7:0] POS_SECTOR_1  = 8'd3;
	localparam logic [7:0] POS_SECTOR_2  = 8'd4;
	localparam logic [7:0] POS_SECTOR_3  = 8'd5;
	localparam logic [7:0] POS_LENGTH_0  = 8'd10;
	localparam logic [7:0] POS_LENGTH_1  = 8'd11;
	localparam logic [7:0] POS_LENGTH_2  = 8'd12;
	localparam logic [7:0] POS_LENGTH_3  = 8'd13;
	localparam logic [7:0] POS_FLAGS     = 8'd25;
	localparam logic [7:0] POS_UNIT_SIZE = 8'd26;
	localparam logic [7:0] POS_GAP       = 8'd27;
	localparam logic [7:0] POS_VOL_SEQ_0 = 8'd28;
	localparam logic [7:0] POS_VOL_SEQ_1 = 8'd29;
	localparam logic [7:0] POS_NAME_LEN  = 8'd32;
	localparam logic [7:0] POS_NAME_0    = 8'd33;

	typedef enum logic [1:0] {
		ST_OK          = 2'd0,
		ST_MALFORMED   = 2'd1,
		ST_UNSUPPORTED = 2'd2
	} status_t;

	typedef enum logic [1:0] {
		NK_REGULAR = 2'd0,
		NK_DOT     = 2'd1,
		NK_DOTDOT  = 2'd2
	} name_kind_t;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       end_of_buffer;
	} byte_item_t;

	typedef struct packed {
		status_t    status;
		logic [7:0] record_length;
		logic       is_directory;
		logic [31:0] extent_sector;
		logic [31:0] data_length;
		logic [7:0] name_length;
		name_kind_t name_kind;
	} result_t;

endpackage

>>> hdl/isodr_in_if.sv
// isodr_in_if: valid/ready channel carrying one record byte per item
// no dependencies

interface isodr_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       end_of_buffer;

	modport source (output valid, output data_byte, output end_of_buffer, input ready);
	modport sink   (input valid, input data_byte, input end_of_buffer, output ready);
endinterface

>>> hdl/isodr_out_if.sv
// isodr_out_if: valid/ready channel carrying one parsed record result per item
// no dependencies

interface isodr_out_if;
	logic        valid;
	logic        ready;
	logic [1:0]  status;
	logic [7:0]  record_length;
	logic        is_directory;
	logic [31:0] extent_sector;
	logic [31:0] data_length;
	logic [7:0]  name_length;
	logic [1:0]  name_kind;

	modport source (output valid, output status, output record_length, output is_directory,
		output extent_sector, output data_length, output name_length, output name_kind,
		input ready);
	modport sink (input valid, input status, input record_length, input is_directory,
		input extent_sector, input data_length, input name_length, input name_kind,
		output ready);
endinterface

>>> hdl/isodr_in_reg.sv
// isodr_in_reg: input register stage for record bytes
// depends on isodr_pkg and isodr_in_if

module isodr_in_reg
	import isodr_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	isodr_in_if.sink   bytes_in,
	input  logic       advance,
	output logic       valid_s1,
	output byte_item_t item_s1
);

	logic take;

	assign bytes_in.ready = !valid_s1 || advance;
	assign take = bytes_in.valid && bytes_in.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (take) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			item_s1 <= '{data_byte: bytes_in.data_byte, end_of_buffer: bytes_in.end_of_buffer};
		end
	end

endmodule

>>> hdl/isodr_parse.sv
// isodr_parse: record state, field latches and result decision for one byte
// depends on isodr_pkg

module isodr_parse
	import isodr_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       step,
	input  byte_item_t item,
	output logic       emit,
	output result_t    result
);

	logic [7:0]  byte_count_q, byte_count_n;
	logic [7:0]  rec_len_q, rec_len_n;
	logic [7:0]  flags_q, flags_n;
	logic        unsup_q, unsup_n;
	logic [7:0]  name_len_q, name_len_n;
	logic [31:0] sector_q, sector_n;
	logic [31:0] length_q, length_n;
	name_kind_t  dot_kind_q, dot_kind_n;
	logic        discarding_q, discarding_n;

	logic [7:0] b;
	logic       eob;
	logic       bad;
	logic       rec_end;
	logic       full;
	status_t    status;

	assign b   = item.data_byte;
	assign eob = item.end_of_buffer;

	always_comb begin
		byte_count_n = byte_count_q;
		rec_len_n    = rec_len_q;
		flags_n      = flags_q;
		unsup_n      = unsup_q;
		name_len_n   = name_len_q;
		sector_n     = sector_q;
		length_n     = length_q;
		dot_kind_n   = dot_kind_q;
		discarding_n = discarding_q;
		bad          = 1'b0;
		rec_end      = 1'b0;
		emit         = 1'b0;
		status       = ST_OK;

		if (discarding_q) begin
			if (eob) begin
				discarding_n = 1'b0;
				byte_count_n = '0;
			end
		end else begin
			unique case (byte_count_q)
				POS_REC_LEN: begin
					rec_len_n  = b;
					unsup_n    = 1'b0;
					dot_kind_n = NK_REGULAR;
					flags_n    = '0;
					name_len_n = '0;
					sector_n   = '0;
					length_n   = '0;
					bad        = (b < MIN_RECORD);
				end
				POS_EXT_ATTR, POS_UNIT_SIZE, POS_GAP, POS_VOL_SEQ_1: begin
					if (b != 8'd0) unsup_n = 1'b1;
				end
				POS_SECTOR_0: sector_n[7:0]   = b;
				POS_SECTOR_1: sector_n[15:8]  = b;
				POS_SECTOR_2: sector_n[23:16] = b;
				POS_SECTOR_3: sector_n[31:24] = b;
				POS_LENGTH_0: length_n[7:0]   = b;
				POS_LENGTH_1: length_n[15:8]  = b;
				POS_LENGTH_2: length_n[23:16] = b;
				POS_LENGTH_3: length_n[31:24] = b;
				POS_FLAGS: begin
					flags_n = b;
					if ((b & BAD_FLAG_MASK) != 8'd0) unsup_n = 1'b1;
				end
				POS_VOL_SEQ_0: begin
					if (b != 8'd1) unsup_n = 1'b1;
				end
				POS_NAME_LEN: begin
					name_len_n = b;
					bad = (b > MAX_NAME) ||
						({1'b0, rec_len_q} < ({1'b0, MIN_RECORD} + {1'b0, b}));
				end
				POS_NAME_0: begin
					if (name_len_q == 8'd1) dot_kind_n = (b != 8'd0) ? NK_DOTDOT : NK_DOT;
				end
				default: ;
			endcase

			rec_end = ({1'b0, byte_count_q} + 9'd1) == {1'b0, rec_len_n};

			priority if (bad) begin
				emit         = 1'b1;
				status       = ST_MALFORMED;
				byte_count_n = '0;
				discarding_n = !eob;
			end else if (rec_end) begin
				emit         = 1'b1;
				status       = unsup_n ? ST_UNSUPPORTED : ST_OK;
				byte_count_n = '0;
			end else if (eob) begin
				emit         = 1'b1;
				status       = ST_MALFORMED;
				byte_count_n = '0;
			end else begin
				byte_count_n = byte_count_q + 8'd1;
			end
		end
	end

	// only a clean record carries its fields; faults report the length alone
	assign full = (status == ST_OK);

	always_comb begin
		result.status        = status;
		result.record_length = rec_len_n;
		result.is_directory  = full ? flags_n[DIR_FLAG_BIT] : 1'b0;
		result.extent_sector = full ? sector_n : '0;
		result.data_length   = full ? length_n : '0;
		result.name_length   = full ? name_len_n : '0;
		result.name_kind     = full ? dot_kind_n : NK_REGULAR;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_count_q <= '0;
			rec_len_q    <= '0;
			flags_q      <= '0;
			unsup_q      <= 1'b0;
			name_len_q   <= '0;
			sector_q     <= '0;
			length_q     <= '0;
			dot_kind_q   <= NK_REGULAR;
			discarding_q <= 1'b0;
		end else if (step) begin
			byte_count_q <= byte_count_n;
			rec_len_q    <= rec_len_n;
			flags_q      <= flags_n;
			unsup_q      <= unsup_n;
			name_len_q   <= name_len_n;
			sector_q     <= sector_n;
			length_q     <= length_n;
			dot_kind_q   <= dot_kind_n;
			discarding_q <= discarding_n;
		end
	end

endmodule

>>> hdl/iso9660_dir_record_parser_unit.sv
// iso9660_dir_record_parser_unit: top level of the directory record parser
// depends on isodr_pkg, isodr_in_if, isodr_out_if, isodr_in_reg, isodr_parse
//
//   channel    dir   payload                                      per item
//   bytes_in   sink  data_byte, end_of_buffer                     one record byte
//   result     src   status, record_length, is_directory,         one record result
//                    extent_sector, data_length, name_length,
//                    name_kind
//
// one byte per cycle while no waiting result stalls; each byte passes the input
// register before the result register loads the result of the record it ends
// reset clears the record position, the latched fields and both valid flags
// a waiting result stalls only a byte that would give a new result; bytes that give
// none keep flowing, and while a byte is held the input register keeps ready low

module iso9660_dir_record_parser_unit
	import isodr_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	isodr_in_if.sink    bytes_in,
	isodr_out_if.source result
);

	logic       valid_s1;
	byte_item_t item_s1;
	logic       advance;
	logic       stall;
	logic       emit;
	result_t    parsed;

	logic       res_valid_s2;
	result_t    res_s2;

	// input register stage
	isodr_in_reg u_in_reg (
		.clk      (clk),
		.arst_n   (arst_n),
		.bytes_in (bytes_in),
		.advance  (advance),
		.valid_s1 (valid_s1),
		.item_s1  (item_s1)
	);

	// record state and result decision
	isodr_parse u_parse (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (advance),
		.item   (item_s1),
		.emit   (emit),
		.result (parsed)
	);

	// hold the byte in stage 1 only if it has a result and the full slot is not taken
	assign stall   = emit && res_valid_s2 && !result.ready;
	assign advance = valid_s1 && !stall;

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_s2 <= 1'b0;
		end else if (advance && emit) begin
			res_valid_s2 <= 1'b1;
		end else if (result.ready) begin
			res_valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && emit) begin
			res_s2 <= parsed;
		end
	end

	assign result.valid         = res_valid_s2;
	assign result.status        = res_s2.status;
	assign result.record_length = res_s2.record_length;
	assign result.is_directory  = res_s2.is_directory;
	assign result.extent_sector = res_s2.extent_sector;
	assign result.data_length   = res_s2.data_length;
	assign result.name_length   = res_s2.name_length;
	assign result.name_kind     = res_s2.name_kind;

endmodule

>>> test/iso9660_dir_record_parser_unit_test.sv
// iso9660_dir_record_parser_unit_test: self-checking bench for the directory record parser
// depends on isodr_pkg, isodr_in_if, isodr_out_if and the parser rtl
`timescale 1ns / 1ps

module iso9660_dir_record_parser_unit_test;
	import isodr_pkg::*;

	typedef logic [7:0] byte_seq_t[$];

	// a run with no accepted item on either channel for this long has hung
	localparam int STALL_LIMIT = 4000;
	// how long the result side is held off during the backpressure test
	localparam int HOLD_OFF_LEN = 300;
	// random part ends once the whole run has sent this many bytes and enough rounds ran
	localparam int TOTAL_BYTES = 950;
	localparam int RANDOM_ROUNDS = 4;

	logic clk = 1'b0;
	logic arst_n;

	isodr_in_if  bytes_in_ch ();
	isodr_out_if result_ch ();

	iso9660_dir_record_parser_unit uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.bytes_in (bytes_in_ch),
		.result   (result_ch)
	);

	always #5 clk = ~clk;

	// shared control between the test tasks and the two channel processes
	logic quiet_mode = 1'b0;   // no idling on either side while set
	int   hold_off_cycles = 0; // result side holds ready low for a hold-off of this length

	// parser state as the bench sees it
	logic [7:0]  rec_pos;
	logic [7:0]  rec_len_acc;
	logic [7:0]  flags_acc;
	logic        unsup_flag;
	logic [7:0]  name_len_acc;
	logic [31:0] sector_acc;
	logic [31:0] length_acc;
	name_kind_t  dot_kind_acc;
	logic        skipping;

	// results the parser owes us, oldest first
	result_t record_results_due[$];

	// bookkeeping
	int bytes_parsed = 0;
	int bytes_skipped = 0;
	int records_predicted = 0;
	int records_checked = 0;
	int fail_count = 0;
	int seen_ok = 0;
	int seen_malformed = 0;
	int seen_unsupported = 0;
	int seen_dot = 0;
	int seen_dotdot = 0;

	// ------------------------------------------------------------------
	// prediction
	// ------------------------------------------------------------------

	// builds the result for the record in progress; only a good record
	// carries the latched fields, every other status reports the length alone
	function automatic result_t record_result(input status_t st, input logic full);
		result_t r;
		r = '0;
		r.status = st;
		r.record_length = rec_len_acc;
		if (full) begin
			r.is_directory  = flags_acc[DIR_FLAG_BIT];
			r.extent_sector = sector_acc;
			r.data_length   = length_acc;
			r.name_length   = name_len_acc;
			r.name_kind     = dot_kind_acc;
		end
		return r;
	endfunction

	// advances the parser by one accepted byte and queues any result it gives
	function automatic void dir_record_step(input logic [7:0] b, input logic eob);
		logic [7:0] pos;
		logic bad;
		pos = rec_pos;
		bad = 1'b0;

		// after a malformed record everything up to the buffer end is dropped
		if (skipping) begin
			bytes_skipped++;
			if (eob) begin
				skipping = 1'b0;
				rec_pos = '0;
			end
			return;
		end
		bytes_parsed++;

		case (pos)
		POS_REC_LEN: begin
			rec_len_acc  = b;
			unsup_flag   = 1'b0;
			dot_kind_acc = NK_REGULAR;
			flags_acc    = '0;
			name_len_acc = '0;
			sector_acc   = '0;
			length_acc   = '0;
			bad = (b < MIN_RECORD);
		end
		POS_EXT_ATTR:
			if (b != 8'd0) unsup_flag = 1'b1;
		POS_SECTOR_0, POS_SECTOR_1, POS_SECTOR_2, POS_SECTOR_3:
			sector_acc[8 * (pos - POS_SECTOR_0) +: 8] = b;
		POS_LENGTH_0, POS_LENGTH_1, POS_LENGTH_2, POS_LENGTH_3:
			length_acc[8 * (pos - POS_LENGTH_0) +: 8] = b;
		POS_FLAGS: begin
			flags_acc = b;
			if ((b & BAD_FLAG_MASK) != 8'd0) unsup_flag = 1'b1;
		end
		POS_UNIT_SIZE, POS_GAP, POS_VOL_SEQ_1:
			if (b != 8'd0) unsup_flag = 1'b1;
		POS_VOL_SEQ_0:
			if (b != 8'd1) unsup_flag = 1'b1;
		POS_NAME_LEN: begin
			name_len_acc = b;
			bad = (b > MAX_NAME) || (int'(rec_len_acc) < int'(MIN_RECORD) + int'(b));
		end
		POS_NAME_0:
			if (name_len_acc == 8'd1) dot_kind_acc = (b != 8'd0) ? NK_DOTDOT : NK_DOT;
		default: ;
		endcase

		if (bad) begin
			// short record or bad name length: report now, drop the rest of the buffer
			record_results_due.push_back(record_result(ST_MALFORMED, 1'b0));
			records_predicted++;
			rec_pos = '0;
			skipping = !eob;
		end else if (int'(pos) + 1 == int'(rec_len_acc)) begin
			// last byte of the record, which may also close the buffer
			if (unsup_flag)
				record_results_due.push_back(record_result(ST_UNSUPPORTED, 1'b0));
			else
				record_results_due.push_back(record_result(ST_OK, 1'b1));
			records_predicted++;
			rec_pos = '0;
		end else if (eob) begin
			// buffer ran out mid record; the next byte opens a fresh one
			record_results_due.push_back(record_result(ST_MALFORMED, 1'b0));
			records_predicted++;
			rec_pos = '0;
		end else begin
			rec_pos = pos + 8'd1;
		end
	endfunction

	// ------------------------------------------------------------------
	// byte sender
	// ------------------------------------------------------------------

	// offers one byte, idling at random first, and returns at the edge that takes it
	task automatic push_byte(input logic [7:0] d, input logic eob);
		while (!quiet_mode && $urandom_range(99) < 17) begin
			bytes_in_ch.valid <= 1'b0;
			@(posedge clk);
		end
		bytes_in_ch.valid         <= 1'b1;
		bytes_in_ch.data_byte     <= d;
		bytes_in_ch.end_of_buffer <= eob;
		do @(posedge clk); while (!bytes_in_ch.ready);
		dir_record_step(d, eob);
	endtask

	// sends the sequence up to the byte flagged as buffer end, or all of it
	task automatic send_bytes(input byte_seq_t seq, input int eob_at);
		int last;
		last = (eob_at < 0) ? seq.size() - 1 : eob_at;
		for (int i = 0; i <= last; i++)
			push_byte(seq[i], i == eob_at);
	endtask

	// sender goes quiet until every owed result has come out
	task automatic wait_for_drain();
		bytes_in_ch.valid <= 1'b0;
		while (record_results_due.size() != 0) @(posedge clk);
	endtask

	// a well-formed record image: supported fields, volume sequence 1, random filler
	function automatic byte_seq_t build_record(input int len, input int name_len,
			input logic [31:0] sector, input logic [31:0] size, input logic [7:0] flags);
		byte_seq_t s;
		for (int i = 0; i < len; i++)
			s.push_back(8'($urandom));
		s[POS_REC_LEN]   = 8'(len);
		s[POS_EXT_ATTR]  = 8'd0;
		for (int i = 0; i < 4; i++) begin
			s[POS_SECTOR_0 + i] = sector[8 * i +: 8];
			s[POS_LENGTH_0 + i] = size[8 * i +: 8];
		end
		s[POS_FLAGS]     = flags;
		s[POS_UNIT_SIZE] = 8'd0;
		s[POS_GAP]       = 8'd0;
		s[POS_VOL_SEQ_0] = 8'd1;
		s[POS_VOL_SEQ_1] = 8'd0;
		s[POS_NAME_LEN]  = 8'(name_len);
		return s;
	endfunction

	// ------------------------------------------------------------------
	// result receiver: random ready, plus a long hold-off on request
	// ------------------------------------------------------------------

	initial begin
		result_ch.ready <= 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(posedge clk);
			if (hold_off_cycles != 0) begin
				// counted here so the sender keeps pushing meanwhile
				result_ch.ready <= 1'b0;
				repeat (hold_off_cycles) @(posedge clk);
				hold_off_cycles = 0;
				result_ch.ready <= 1'b1;
			end else begin
				result_ch.ready <= quiet_mode || ($urandom_range(99) >= 17);
			end
		end
	end

	// ------------------------------------------------------------------
	// result checker
	// ------------------------------------------------------------------

	always @(posedge clk) begin : check_results
		result_t got;
		result_t want;
		if (arst_n === 1'b1 && result_ch.valid === 1'b1 && result_ch.ready === 1'b1) begin
			got.status        = status_t'(result_ch.status);
			got.record_length = result_ch.record_length;
			got.is_directory  = result_ch.is_directory;
			got.extent_sector = result_ch.extent_sector;
			got.data_length   = result_ch.data_length;
			got.name_length   = result_ch.name_length;
			got.name_kind     = name_kind_t'(result_ch.name_kind);
			if (record_results_due.size() == 0) begin
				fail_count++;
				if (fail_count <= 10)
					$display("unexpected result: status %0d length %0d", got.status,
						got.record_length);
			end else begin
				want = record_results_due.pop_front();
				records_checked++;
				case (want.status)
				ST_OK: begin
					seen_ok++;
					if (want.name_kind == NK_DOT) seen_dot++;
					if (want.name_kind == NK_DOTDOT) seen_dotdot++;
				end
				ST_MALFORMED:   seen_malformed++;
				ST_UNSUPPORTED: seen_unsupported++;
				default: ;
				endcase
				if (got.status !== want.status || got.record_length !== want.record_length
						|| got.is_directory !== want.is_directory
						|| got.extent_sector !== want.extent_sector
						|| got.data_length !== want.data_length
						|| got.name_length !== want.name_length
						|| got.name_kind !== want.name_kind) begin
					fail_count++;
					if (fail_count <= 10) begin
						$display("mismatch on record %0d", records_checked);
						$display("  got  st %0d len %0d dir %0d ext %h size %h name %0d kind %0d",
							got.status, got.record_length, got.is_directory,
							got.extent_sector, got.data_length, got.name_length,
							got.name_kind);
						$display("  want st %0d len %0d dir %0d ext %h size %h name %0d kind %0d",
							want.status, want.record_length, want.is_directory,
							want.extent_sector, want.data_length, want.name_length,
							want.name_kind);
					end
				end
			end
		end
	end

	// ------------------------------------------------------------------
	// watchdog: too long with nothing accepted on either side ends the run
	// ------------------------------------------------------------------

	initial begin : watchdog
		int idle_run;
		idle_run = 0;
		wait (arst_n === 1'b1);
		while (idle_run < STALL_LIMIT) begin
			@(posedge clk);
			if ((bytes_in_ch.valid && bytes_in_ch.ready) || (result_ch.valid && result_ch.ready))
				idle_run = 0;
			else
				idle_run++;
		end
		$display("timeout: nothing accepted for %0d cycles, %0d results outstanding",
			STALL_LIMIT, record_results_due.size());
		$display("iso9660_dir_record_parser_unit_test NOT OK");
		$finish;
	end

	// ------------------------------------------------------------------
	// tests
	// ------------------------------------------------------------------

	// hand-picked records: field extremes, dot entries and every fault the parser knows
	task automatic test_directed_records();
		byte_seq_t s;
		logic [7:0] odd_pos [8];
		logic [7:0] odd_val [8];
		odd_pos = '{POS_EXT_ATTR, POS_FLAGS, POS_FLAGS, POS_UNIT_SIZE, POS_GAP,
			POS_VOL_SEQ_0, POS_VOL_SEQ_0, POS_VOL_SEQ_1};
		odd_val = '{8'h01, 8'h80, 8'h04, 8'hFF, 8'h01, 8'h00, 8'h02, 8'h01};

		// smallest good record, all-ones extent and size, no name
		s = build_record(33, 0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 8'h00);
		send_bytes(s, -1);
		// largest record with the longest name, a directory, buffer closes on its last byte
		s = build_record(255, 222, 32'h0000_0000, 32'h8000_0001, 8'h02);
		send_bytes(s, s.size() - 1);
		// dot and dotdot entries
		s = build_record(34, 1, $urandom, $urandom, 8'h02);
		s[POS_NAME_0] = 8'h00;
		send_bytes(s, -1);
		s = build_record(34, 1, $urandom, $urandom, 8'h02);
		s[POS_NAME_0] = 8'h01;
		send_bytes(s, -1);
		s = build_record(34, 1, $urandom, $urandom, 8'h01);
		s[POS_NAME_0] = 8'hFF;
		send_bytes(s, -1);
		// two-byte name starting with zero is still a regular name; both low flag bits
		s = build_record(35, 2, $urandom, $urandom, 8'h03);
		s[POS_NAME_0] = 8'h00;
		send_bytes(s, -1);

		// short record that also ends the buffer: no discarding
		push_byte(8'd0, 1'b1);
		// short record mid-buffer: the following bytes up to buffer end are dropped
		push_byte(8'd32, 1'b0);
		push_byte(8'hFF, 1'b0);
		push_byte(8'd40, 1'b0);
		push_byte(8'h00, 1'b1);
		// length byte fine but buffer ends on it
		push_byte(8'd33, 1'b1);

		// name length over the limit, then the tail is discarded
		s = build_record(255, 0, $urandom, $urandom, 8'h00);
		s[POS_NAME_LEN] = 8'd223;
		send_bytes(s, 36);
		// name does not fit in the record
		s = build_record(40, 8, $urandom, $urandom, 8'h00);
		send_bytes(s, 35);
		// same fault with the buffer ending right on the name length byte
		s = build_record(50, 20, $urandom, $urandom, 8'h00);
		send_bytes(s, POS_NAME_LEN);
		// cut off part way through
		s = build_record(60, 10, $urandom, $urandom, 8'h02);
		send_bytes(s, 20);

		// each unsupported feature on its own
		for (int k = 0; k < 8; k++) begin
			s = build_record(33, 0, $urandom, $urandom, 8'h02);
			s[odd_pos[k]] = odd_val[k];
			send_bytes(s, -1);
		end
		// unsupported record cut short is reported as malformed
		s = build_record(60, 5, $urandom, $urandom, 8'h00);
		s[POS_EXT_ATTR] = 8'h01;
		send_bytes(s, 30);
		// unsupported record with a bad name length is malformed too
		s = build_record(60, 250, $urandom, $urandom, 8'h00);
		s[POS_UNIT_SIZE] = 8'h01;
		send_bytes(s, 33);
	endtask

	// result side held off while records keep coming, then a full drain
	task automatic test_result_backpressure();
		byte_seq_t s;
		hold_off_cycles = HOLD_OFF_LEN;
		// one-byte short records each give a result, so the block fills fast
		for (int i = 0; i < 12; i++)
			push_byte(8'($urandom_range(32, 0)), 1'b1);
		s = build_record(40, 4, $urandom, $urandom, 8'h02);
		send_bytes(s, -1);
		wait_for_drain();
		for (int i = 0; i < 1; i++) begin
			s = build_record(33 + i, i, $urandom, $urandom, 8'($urandom_range(3)));
			send_bytes(s, -1);
		end
	endtask

	// mostly well-formed records with random content, plus faults and raw noise
	task automatic test_random_stream();
		byte_seq_t s;
		int iter;
		int roll;
		int len;
		int max_name;
		int nl;
		int eob_at;
		int n;
		iter = 0;
		while (bytes_parsed + bytes_skipped < TOTAL_BYTES || iter < RANDOM_ROUNDS) begin
			// one long stretch with no idling on either side
			quiet_mode = (iter >= 1 && iter < 4);
			iter++;

			// most records small, a few up to the full length
			len = ($urandom_range(19) == 0) ? $urandom_range(255, 33) : $urandom_range(64, 33);
			max_name = (len - 33 > 222) ? 222 : len - 33;
			if (max_name >= 1 && $urandom_range(3) == 0)
				nl = 1;
			else
				nl = $urandom_range(max_name, 0);
			s = build_record(len, nl, $urandom, $urandom, 8'($urandom_range(3)));
			if (nl == 1 && $urandom_range(2) == 0)
				s[POS_NAME_0] = 8'h00;
			eob_at = ($urandom_range(99) < 30) ? len - 1 : -1;

			roll = $urandom_range(99);
			if (roll < 55) begin
				send_bytes(s, eob_at);
			end else if (roll < 70) begin
				// spoil one of the fields that must hold a fixed value
				case ($urandom_range(5))
				0: s[POS_EXT_ATTR] = 8'($urandom_range(255, 1));
				1: s[POS_FLAGS] = s[POS_FLAGS] | (8'($urandom_range(63, 1)) << 2);
				2: s[POS_UNIT_SIZE] = 8'($urandom_range(255, 1));
				3: s[POS_GAP] = 8'($urandom_range(255, 1));
				4: begin
					s[POS_VOL_SEQ_0] = 8'($urandom);
					if (s[POS_VOL_SEQ_0] == 8'd1) s[POS_VOL_SEQ_0] = 8'd0;
				end
				default: s[POS_VOL_SEQ_1] = 8'($urandom_range(255, 1));
				endcase
				send_bytes(s, eob_at);
			end else if (roll < 80) begin
				// buffer ends before the record does
				send_bytes(s, $urandom_range(len - 2, 0));
			end else if (roll < 88) begin
				// name length too big for the limit or for the record
				if ($urandom_range(1) == 0)
					s[POS_NAME_LEN] = 8'($urandom_range(255, 223));
				else
					s[POS_NAME_LEN] = 8'($urandom_range(255, len - 32));
				eob_at = ($urandom_range(3) == 0) ? POS_NAME_LEN
					: POS_NAME_LEN + $urandom_range(30, 1);
				while (s.size() <= eob_at)
					s.push_back(8'($urandom));
				send_bytes(s, eob_at);
			end else if (roll < 95) begin
				// short record, maybe followed by bytes to be discarded
				s = {};
				s.push_back(8'($urandom_range(32, 0)));
				n = ($urandom_range(1) == 0) ? 0 : $urandom_range(20, 1);
				for (int i = 0; i < n; i++)
					s.push_back(8'($urandom));
				send_bytes(s, n);
			end else begin
				// raw noise, then a buffer-end byte so the next record starts aligned
				n = $urandom_range(40, 1);
				for (int i = 0; i < n; i++)
					push_byte(8'($urandom), $urandom_range(9) == 0);
				push_byte(8'($urandom), 1'b1);
			end
		end
		quiet_mode = 1'b0;
	endtask

	// ------------------------------------------------------------------
	// sequence of the run
	// ------------------------------------------------------------------

	initial begin
		arst_n <= 1'b0;
		bytes_in_ch.valid         <= 1'b0;
		bytes_in_ch.data_byte     <= 8'd0;
		bytes_in_ch.end_of_buffer <= 1'b0;

		// bench copy of the parser starts from its reset state
		rec_pos      = '0;
		rec_len_acc  = '0;
		flags_acc    = '0;
		unsup_flag   = 1'b0;
		name_len_acc = '0;
		sector_acc   = '0;
		length_acc   = '0;
		dot_kind_acc = NK_REGULAR;
		skipping     = 1'b0;

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed_records();
		test_result_backpressure();
		test_random_stream();

		// let the last results out, then wait for anything stray
		wait_for_drain();
		repeat (8) @(posedge clk);

		$display("covered %0d parsed bytes and %0d discarded, %0d records checked",
			bytes_parsed, bytes_skipped, records_checked);
		$display("  %0d good (%0d dot, %0d dotdot), %0d malformed, %0d unsupported, %0d failures",
			seen_ok, seen_dot, seen_dotdot, seen_malformed, seen_unsupported, fail_count);
		if (fail_count == 0 && record_results_due.size() == 0)
			$display("iso9660_dir_record_parser_unit_test OK");
		else
			$display("iso9660_dir_record_parser_unit_test NOT OK");
		$finish;
	end

endmodule
